>>> sv/upd_pkg.sv
// Shared types and constants for the URL percent decoder.
`timescale 1ns / 1ps
`default_nettype none
package upd_pkg;

	localparam int unsigned MAX_BYTES = 6;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PCT  = 2'd1;
	localparam logic [1:0] PH_HEX  = 2'd2;
	localparam logic [1:0] PH_UNI  = 2'd3;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_U     = 8'h75;

	localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
	localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
	localparam logic [15:0] CP_SURR_LO    = 16'hD800;
	localparam logic [15:0] CP_SURR_HI    = 16'hE000;

	// One queue entry: the result bytes caused by one input transaction.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      eos;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

>>> sv/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata[7:0] in_byte, tlast last_byte
//  m_*       out  m_tvalid/m_tready  tdata[7:0] out_byte, tuser has_byte, tlast end_of_string
//  cfg_*     in   cfg_we             cfg_wdata plus_as_space
//
// One input transaction per cycle while the queue has room; each yields 0 to 6
// output transactions, sent at one per cycle by the back end while m_tready is high.
// Throughput is set by the output serializer, which sends each result byte as its own transaction.
// From input to output, data passes through the queue, the current entry and the output register.
// Reset clears escape state, queue and output; plus_as_space resets to 0.
`timescale 1ns / 1ps
`default_nettype none
module url_percent_decoder #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic            m_tuser,   // [0] has_byte
	output logic            m_tlast
);

	upd_pkg::entry_t  f_ent;
	upd_pkg::entry_t  q_data;
	upd_pkg::q_stat_t q_stat;
	logic             f_push;
	logic             q_pop;
	logic             accept;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.in_byte   (s_tdata),
		.last_byte (s_tlast),
		.ent       (f_ent),
		.ent_push  (f_push)
	);

	upd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_ent),
		.pop    (q_pop),
		.rdata  (q_data),
		.stat   (q_stat)
	);

	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (q_data),
		.q_stat   (q_stat),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef ASSERT_OFF
	a_bare_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata == 8'd0)
		else $error("bare marker without end of string or with data");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_stat.full && accept)
		else $error("queue push without an accepted transaction or room");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

>>> sv/upd_front.sv
// Front end: escape tracking and expansion of each input byte into a result list.
`timescale 1ns / 1ps
`default_nettype none
module upd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic            cfg_wdata,
	input  wire logic            accept,
	input  wire logic [7:0]      in_byte,
	input  wire logic            last_byte,
	output upd_pkg::entry_t      ent,
	output logic                 ent_push
);

	logic        plus_q;
	logic [1:0]  ph_q;
	logic [1:0]  cnt_q;
	logic [11:0] val_q;
	logic [7:0]  held_q [4];

	logic [1:0]  ph;
	logic [1:0]  cnt;
	logic [11:0] val;
	logic [7:0]  held_n [4];
	logic [upd_pkg::MAX_BYTES-1:0][7:0] lst;
	logic [2:0]  n;
	logic        fail;
	logic        do_idle;
	logic        hx;
	logic [3:0]  hv;
	logic [15:0] code;

	always_comb begin
		hx = 1'b1;
		hv = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hv = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			hv = 4'(in_byte - 8'h37);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			hv = 4'(in_byte - 8'h57);
		end else begin
			hx = 1'b0;
		end
	end

	always_comb begin
		ph      = ph_q;
		cnt     = cnt_q;
		val     = val_q;
		held_n  = held_q;
		lst     = '0;
		n       = 3'd0;
		fail    = 1'b0;
		do_idle = 1'b0;
		code    = {val_q, hv};
		unique case (ph_q)
			upd_pkg::PH_IDLE: begin
				do_idle = 1'b1;
			end
			upd_pkg::PH_PCT: begin
				if (in_byte == upd_pkg::CH_U) begin
					ph  = upd_pkg::PH_UNI;
					cnt = 2'd0;
					val = '0;
				end else if (hx) begin
					held_n[0] = in_byte;
					val       = {8'd0, hv};
					cnt       = 2'd1;
					ph        = upd_pkg::PH_HEX;
				end else begin
					fail = 1'b1;
				end
			end
			upd_pkg::PH_HEX: begin
				if (hx) begin
					lst[n] = {val_q[3:0], hv};
					n      = n + 3'd1;
					ph     = upd_pkg::PH_IDLE;
					cnt    = 2'd0;
					val    = '0;
				end else begin
					fail = 1'b1;
				end
			end
			upd_pkg::PH_UNI: begin
				if (hx) begin
					held_n[cnt_q] = in_byte;
					if (cnt_q == 2'd3) begin
						ph  = upd_pkg::PH_IDLE;
						cnt = 2'd0;
						val = '0;
						if (code < upd_pkg::CP_TWO_BYTE) begin
							lst[n] = code[7:0];
							n      = n + 3'd1;
						end else if (code < upd_pkg::CP_THREE_BYTE) begin
							lst[n] = {3'b110, code[10:6]};
							n      = n + 3'd1;
							lst[n] = {2'b10, code[5:0]};
							n      = n + 3'd1;
						end else if (code >= upd_pkg::CP_SURR_LO
								&& code < upd_pkg::CP_SURR_HI) begin
							// surrogate: consumed silently
						end else begin
							lst[n] = {4'b1110, code[15:12]};
							n      = n + 3'd1;
							lst[n] = {2'b10, code[11:6]};
							n      = n + 3'd1;
							lst[n] = {2'b10, code[5:0]};
							n      = n + 3'd1;
						end
					end else begin
						cnt = cnt_q + 2'd1;
						val = code[11:0];
					end
				end else begin
					fail = 1'b1;
				end
			end
		endcase

		if (fail) begin
			lst[n] = upd_pkg::CH_PCT;
			n      = n + 3'd1;
			if (ph_q == upd_pkg::PH_UNI) begin
				lst[n] = upd_pkg::CH_U;
				n      = n + 3'd1;
			end
			for (int k = 0; k < 4; k++) begin
				if (k < int'(cnt_q)) begin
					lst[n] = held_q[k];
					n      = n + 3'd1;
				end
			end
			ph      = upd_pkg::PH_IDLE;
			cnt     = 2'd0;
			val     = '0;
			do_idle = 1'b1;
		end

		if (do_idle) begin
			if (in_byte == upd_pkg::CH_PCT) begin
				ph  = upd_pkg::PH_PCT;
				cnt = 2'd0;
				val = '0;
			end else begin
				lst[n] = (plus_q && in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE
					: in_byte;
				n      = n + 3'd1;
			end
		end

		// escape still open at end of string: pass it through literally
		if (last_byte && ph != upd_pkg::PH_IDLE) begin
			lst[n] = upd_pkg::CH_PCT;
			n      = n + 3'd1;
			if (ph == upd_pkg::PH_UNI) begin
				lst[n] = upd_pkg::CH_U;
				n      = n + 3'd1;
			end
			for (int k = 0; k < 4; k++) begin
				if (k < int'(cnt)) begin
					lst[n] = held_n[k];
					n      = n + 3'd1;
				end
			end
			ph  = upd_pkg::PH_IDLE;
			cnt = 2'd0;
			val = '0;
		end
	end

	assign ent.bytes = lst;
	assign ent.cnt   = n;
	assign ent.eos   = last_byte;
	assign ent_push  = accept && (n != 3'd0 || last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_q <= 1'b0;
			ph_q   <= upd_pkg::PH_IDLE;
			cnt_q  <= 2'd0;
			val_q  <= '0;
		end else begin
			if (cfg_we) begin
				plus_q <= cfg_wdata;
			end
			if (accept) begin
				ph_q  <= ph;
				cnt_q <= cnt;
				val_q <= val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_n;
		end
	end

endmodule
`default_nettype wire

>>> sv/upd_fifo.sv
// Short queue of result lists between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module upd_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire upd_pkg::entry_t   wdata,
	input  wire logic              pop,
	output upd_pkg::entry_t        rdata,
	output upd_pkg::q_stat_t       stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	upd_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/upd_back.sv
// Back end: serializes each result list onto the output stream, one byte per transaction.
`timescale 1ns / 1ps
`default_nettype none
module upd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire upd_pkg::entry_t  q_data,
	input  wire upd_pkg::q_stat_t q_stat,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tuser,
	output logic                  m_tlast
);

	upd_pkg::entry_t cur_q;
	logic            cur_vld_q;
	logic [2:0]      idx_q;
	logic            out_vld_q;
	logic [7:0]      out_byte_q;
	logic            out_has_q;
	logic            out_eos_q;

	logic adv;
	logic fin;
	logic emit;

	assign adv  = !out_vld_q || m_tready;
	assign fin  = (cur_q.cnt == 3'd0) || (idx_q == cur_q.cnt - 3'd1);
	assign emit = adv && cur_vld_q;
	assign pop  = !q_stat.empty && (!cur_vld_q || (emit && fin));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= 3'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_vld_q <= 1'b1;
				idx_q     <= 3'd0;
			end else if (emit && fin) begin
				cur_vld_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
			end
			if (adv) begin
				out_vld_q <= cur_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
		if (emit) begin
			out_has_q  <= (cur_q.cnt != 3'd0);
			out_byte_q <= (cur_q.cnt != 3'd0) ? cur_q.bytes[idx_q] : 8'd0;
			out_eos_q  <= cur_q.eos && fin;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_eos_q;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the streaming URL percent decoder.
`timescale 1ns / 1ps
module tb;

	localparam int unsigned RST_CYCLES  = 8;
	localparam int unsigned SETTLE_CYC  = 8;
	localparam int unsigned HOLD_CYCLES = 100;
	localparam int unsigned STALL_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       eos;
	} dec_byte_t;

	typedef logic [7:0] chr_q_t[$];

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_wdata;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	url_percent_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// decoder model state
	logic        plus_mode;
	logic [1:0]  esc_phase;
	logic [2:0]  esc_cnt;
	logic [15:0] esc_val;
	logic [7:0]  held_chr[4];

	dec_byte_t   step_out[$];
	dec_byte_t   expected_bytes[$];

	int          errors;
	int          items_sent;
	bit          idle_en;
	bit          hold_req;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void push_out(input logic [7:0] b);
		step_out.push_back('{data: b, has: 1'b1, eos: 1'b0});
	endfunction

	function automatic void clear_escape();
		esc_phase = upd_pkg::PH_IDLE;
		esc_cnt   = 3'd0;
		esc_val   = 16'd0;
	endfunction

	function automatic void flush_escape();
		push_out(upd_pkg::CH_PCT);
		if (esc_phase == upd_pkg::PH_UNI)
			push_out(upd_pkg::CH_U);
		for (int k = 0; k < int'(esc_cnt) && k < 4; k++)
			push_out(held_chr[k]);
		clear_escape();
	endfunction

	function automatic void take_plain(input logic [7:0] c);
		if (c == upd_pkg::CH_PCT) begin
			clear_escape();
			esc_phase = upd_pkg::PH_PCT;
		end else if (plus_mode && c == upd_pkg::CH_PLUS) begin
			push_out(upd_pkg::CH_SPACE);
		end else begin
			push_out(c);
		end
	endfunction

	function automatic void decode_char(input logic [7:0] c, input logic last);
		logic [3:0] v;
		bit         is_hex;
		dec_byte_t  tail;
		step_out.delete();
		is_hex = hex_digit(c, v);
		case (esc_phase)
			upd_pkg::PH_IDLE: begin
				take_plain(c);
			end
			upd_pkg::PH_PCT: begin
				if (c == upd_pkg::CH_U) begin
					clear_escape();
					esc_phase = upd_pkg::PH_UNI;
				end else if (is_hex) begin
					held_chr[0] = c;
					esc_val     = {12'd0, v};
					esc_cnt     = 3'd1;
					esc_phase   = upd_pkg::PH_HEX;
				end else begin
					flush_escape();
					take_plain(c);
				end
			end
			upd_pkg::PH_HEX: begin
				if (is_hex) begin
					push_out({esc_val[3:0], v});
					clear_escape();
				end else begin
					flush_escape();
					take_plain(c);
				end
			end
			default: begin
				if (is_hex) begin
					held_chr[esc_cnt[1:0]] = c;
					esc_val = {esc_val[11:0], v};
					esc_cnt = esc_cnt + 3'd1;
					if (esc_cnt >= 3'd4) begin
						if (esc_val < upd_pkg::CP_TWO_BYTE) begin
							push_out(esc_val[7:0]);
						end else if (esc_val < upd_pkg::CP_THREE_BYTE) begin
							push_out({3'b110, esc_val[10:6]});
							push_out({2'b10, esc_val[5:0]});
						end else if (esc_val >= upd_pkg::CP_SURR_LO
								&& esc_val < upd_pkg::CP_SURR_HI) begin
							// surrogate: dropped
						end else begin
							push_out({4'b1110, esc_val[15:12]});
							push_out({2'b10, esc_val[11:6]});
							push_out({2'b10, esc_val[5:0]});
						end
						clear_escape();
					end
				end else begin
					flush_escape();
					take_plain(c);
				end
			end
		endcase
		if (last) begin
			if (esc_phase != upd_pkg::PH_IDLE)
				flush_escape();
			if (step_out.size() == 0) begin
				step_out.push_back('{data: 8'd0, has: 1'b0, eos: 1'b1});
			end else begin
				tail = step_out.pop_back();
				tail.eos = 1'b1;
				step_out.push_back(tail);
			end
		end
		foreach (step_out[i])
			expected_bytes.push_back(step_out[i]);
	endfunction

	function automatic logic [7:0] hex_chr(input logic [3:0] n);
		if (n < 4'd10)
			return "0" + 8'(n);
		return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		$display("%0t: %s: expected %02h, got %02h", $time, what, exp_v, got_v);
		errors++;
	endtask

	task automatic send_item(input logic [7:0] b, input logic last);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		decode_char(b, last);
		items_sent++;
	endtask

	task automatic send_string(input chr_q_t s);
		for (int i = 0; i < s.size(); i++)
			send_item(s[i], i == s.size() - 1);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_plus_mode(input logic v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		plus_mode = v;
		cfg_we    <= 1'b0;
	endtask

	task automatic send_random_string();
		chr_q_t      s;
		int          kind;
		int          nd;
		logic [15:0] cp;
		repeat ($urandom_range(1, 6)) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: s.push_back(8'($urandom_range(0, 255)));
				3: s.push_back(upd_pkg::CH_PLUS);
				4, 5: begin
					s.push_back(upd_pkg::CH_PCT);
					s.push_back(hex_chr(4'($urandom_range(0, 15))));
					s.push_back(hex_chr(4'($urandom_range(0, 15))));
				end
				6, 7: begin
					case ($urandom_range(0, 3))
						0: cp = 16'($urandom_range(0, 16'h007F));
						1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
						2: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
						default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
					endcase
					s.push_back(upd_pkg::CH_PCT);
					s.push_back(upd_pkg::CH_U);
					s.push_back(hex_chr(cp[15:12]));
					s.push_back(hex_chr(cp[11:8]));
					s.push_back(hex_chr(cp[7:4]));
					s.push_back(hex_chr(cp[3:0]));
				end
				default: begin
					// broken escape (kind 8) or one left open
					s.push_back(upd_pkg::CH_PCT);
					if ($urandom_range(0, 1)) begin
						s.push_back(upd_pkg::CH_U);
						nd = $urandom_range(0, 3);
					end else begin
						nd = $urandom_range(0, 1);
					end
					repeat (nd) s.push_back(hex_chr(4'($urandom_range(0, 15))));
					if (kind == 8)
						s.push_back(8'($urandom_range(0, 255)));
				end
			endcase
		end
		send_string(s);
	endtask

	task automatic run_random(input int n);
		int start;
		start = items_sent;
		while (items_sent - start < n)
			send_random_string();
	endtask

	task automatic test_literal_and_escapes();
		chr_q_t s;
		set_plus_mode(1'b0);
		s = '{8'h00, 8'hFF, upd_pkg::CH_PLUS};
		send_string(s);
		s = '{upd_pkg::CH_PCT, "f", "F"};
		send_string(s);
		s = '{upd_pkg::CH_PCT, upd_pkg::CH_U, "0", "7", "F", "F"};
		send_string(s);
		// surrogate at end of string leaves only the bare end marker
		s = '{upd_pkg::CH_PCT, upd_pkg::CH_U, "D", "8", "0", "0"};
		send_string(s);
		s = '{upd_pkg::CH_PCT, upd_pkg::CH_PCT, "4", "G"};
		send_string(s);
		s = '{upd_pkg::CH_PCT, upd_pkg::CH_U, "1"};
		send_string(s);
	endtask

	task automatic test_plus_mode();
		chr_q_t s;
		set_plus_mode(1'b1);
		s = '{upd_pkg::CH_PLUS, upd_pkg::CH_PCT, upd_pkg::CH_PLUS};
		send_string(s);
		s = '{upd_pkg::CH_PCT};
		send_string(s);
	endtask

	task automatic test_random_plus();
		set_plus_mode(1'b1);
		run_random(50);
	endtask

	task automatic test_random_literal();
		set_plus_mode(1'b0);
		run_random(50);
	endtask

	task automatic test_backpressure();
		chr_q_t s;
		drain();
		hold_req = 1'b1;
		repeat (24) s.push_back(8'($urandom_range(8'h30, 8'h7A)));
		send_string(s);
	endtask

	task automatic test_no_idle();
		set_plus_mode(1'b1);
		idle_en = 1'b0;
		run_random(40);
	endtask

	// output side: random stalls, plus one long hold on request
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : chk
		dec_byte_t r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected output transaction", 8'd0, m_tdata);
			end else begin
				r = expected_bytes.pop_front();
				if (m_tdata !== r.data)
					report_mismatch("out_byte", r.data, m_tdata);
				if (m_tuser !== r.has)
					report_mismatch("has_byte", {7'd0, r.has}, {7'd0, m_tuser});
				if (m_tlast !== r.eos)
					report_mismatch("end_of_string", {7'd0, r.eos}, {7'd0, m_tlast});
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'd0;
		s_tlast   <= 1'b0;
		errors     = 0;
		items_sent = 0;
		idle_en    = 1'b1;
		hold_req   = 1'b0;
		plus_mode  = 1'b0;
		clear_escape();
		foreach (held_chr[i])
			held_chr[i] = 8'd0;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_literal_and_escapes();
		test_plus_mode();
		test_random_plus();
		test_random_literal();
		test_backpressure();
		test_no_idle();

		drain();
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_fifo.sv
sv/upd_back.sv
sv/url_percent_decoder.sv
tb/sv/tb.sv
